/* hw/rtl/framed_block_receiver_core_defines.svh */
// assertion macros for the framed block receiver checker
`ifndef FRAMED_BLOCK_RECEIVER_CORE_DEFINES_SVH
`define FRAMED_BLOCK_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FBR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FBR_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fbr_pkg.sv */
// shared types and constants of the framed block receiver
package fbr_pkg;

    localparam int BUF_BYTES = 256;
    localparam int BUF_AW    = $clog2(BUF_BYTES);
    localparam int BUF_CW    = $clog2(BUF_BYTES + 1);
    localparam int PADDR_W   = 4;

    localparam logic [7:0]  START_CODE   = 8'hAA;
    localparam logic [7:0]  ACK_CODE     = 8'h79;
    localparam logic [7:0]  NACK_CODE    = 8'h1F;
    localparam logic [31:0] BASE_RESET   = 32'h0800_C800;
    localparam logic [15:0] HDR_TO_RESET = 16'd1000;
    localparam logic [15:0] DAT_TO_RESET = 16'd1000;
    localparam logic [15:0] SUM_TO_RESET = 16'd500;

    localparam logic [1:0] REG_BASE    = 2'd0;
    localparam logic [1:0] REG_HDR_TO  = 2'd1;
    localparam logic [1:0] REG_DAT_TO  = 2'd2;
    localparam logic [1:0] REG_SUM_TO  = 2'd3;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic        reply_valid;
        logic [7:0]  reply_byte;
        logic        write_valid;
        logic [31:0] write_address;
        logic [31:0] write_word;
        logic [2:0]  write_byte_count;
        logic        last;
        logic        finished;
    } t_out_word;

endpackage

/* hw/rtl/framed_block_receiver_core.sv */
// framed block receiver core: frame parser, data buffer and write word emitter
//
// input channel (i_in_valid / o_in_ready, i_in_word): one word is either a
// received serial byte or a millisecond tick. a word is taken whenever the
// emitter is idle and the output register is free or being drained in the
// same cycle. header, length and timeout replies leave in the cycle after the
// word is taken.
// output channel (o_out_valid / i_out_ready, o_out_word): one registered
// result word. a good frame of n bytes is read back from the dual-port frame
// buffer byte by byte, each byte read and then captured into the write word,
// and each write word is loaded into the output register, waiting while the
// receiver stalls; no input word is taken until the last write word is loaded.
// a stalled output word holds its value until taken.
// configuration: apb registers base address, header, data and checksum
// timeouts. the user writes them only while the block is idle; not enforced.
// reset: hunting for the start byte, registers at their defaults, output empty;
// after a zero-length frame the block ignores all input until reset.
module framed_block_receiver_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  fbr_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output fbr_pkg::t_out_word          o_out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import fbr_pkg::*;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_SUM_HI = 3'd4;
    localparam logic [2:0] PH_SUM_LO = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_RD   = 2'd1;
    localparam logic [1:0] SEQ_CAP  = 2'd2;
    localparam logic [1:0] SEQ_OUT  = 2'd3;

    logic [31:0]       r_base,      n_base;
    logic [15:0]       r_hdr_to,    n_hdr_to;
    logic [15:0]       r_dat_to,    n_dat_to;
    logic [15:0]       r_sum_to,    n_sum_to;
    logic [2:0]        r_phase,     n_phase;
    logic [15:0]       r_frame_len, n_frame_len;
    logic [BUF_CW-1:0] r_bytes_rx,  n_bytes_rx;
    logic [15:0]       r_sum,       n_sum;
    logic [7:0]        r_sum_hi,    n_sum_hi;
    logic [15:0]       r_elapsed,   n_elapsed;
    logic [31:0]       r_next_addr, n_next_addr;
    logic [1:0]        r_seq,       n_seq;
    logic [BUF_CW-1:0] r_idx,       n_idx;
    logic [31:0]       r_word,      n_word;
    logic [2:0]        r_cnt,       n_cnt;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out,       n_out;

    logic              out_free;
    logic              in_fire;
    logic              cfg_we;
    logic [15:0]       elapsed_inc;
    logic [15:0]       limit;
    logic [15:0]       len_full;
    logic [15:0]       sum_recv;
    logic [BUF_CW-1:0] bytes_inc;
    logic [BUF_CW-1:0] idx_inc;
    logic [BUF_CW-1:0] len_cnt;
    logic              word_last;
    logic              ram_we;
    logic [BUF_AW-1:0] ram_waddr;
    logic [7:0]        ram_rdata;

    fbr_ram #(
        .WIDTH(8),
        .DEPTH(BUF_BYTES)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_in_word.rx_byte),
        .i_raddr(r_idx[BUF_AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_seq == SEQ_IDLE) && out_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign cfg_we      = psel && penable && pwrite;
    assign elapsed_inc = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;
    assign len_full    = {r_frame_len[15:8], i_in_word.rx_byte};
    assign sum_recv    = {r_sum_hi, i_in_word.rx_byte};
    assign bytes_inc   = r_bytes_rx + 1'b1;
    assign idx_inc     = r_idx + 1'b1;
    assign len_cnt     = r_frame_len[BUF_CW-1:0];
    assign word_last   = (r_idx == len_cnt);
    assign ram_waddr   = r_bytes_rx[BUF_AW-1:0];

    always_comb begin
        case (r_phase)
            PH_LEN_HI: limit = r_hdr_to;
            PH_LEN_LO: limit = r_hdr_to;
            PH_DATA:   limit = r_dat_to;
            default:   limit = r_sum_to;
        endcase
    end

    always_comb begin
        n_base      = r_base;
        n_hdr_to    = r_hdr_to;
        n_dat_to    = r_dat_to;
        n_sum_to    = r_sum_to;
        n_phase     = r_phase;
        n_frame_len = r_frame_len;
        n_bytes_rx  = r_bytes_rx;
        n_sum       = r_sum;
        n_sum_hi    = r_sum_hi;
        n_elapsed   = r_elapsed;
        n_next_addr = r_next_addr;
        n_seq       = r_seq;
        n_idx       = r_idx;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (in_fire && r_phase < PH_DONE) begin
            if (i_in_word.req_type == REQ_TICK) begin
                if (r_phase != PH_HUNT) begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc >= limit) begin
                        n_phase           = PH_HUNT;
                        n_elapsed         = 16'd0;
                        n_out             = '0;
                        n_out.reply_valid = 1'b1;
                        n_out.reply_byte  = NACK_CODE;
                        n_out.last        = 1'b1;
                        n_out_valid       = 1'b1;
                    end
                end
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (i_in_word.rx_byte == START_CODE) begin
                            n_phase   = PH_LEN_HI;
                            n_elapsed = 16'd0;
                        end
                    end
                    PH_LEN_HI: begin
                        n_frame_len = {i_in_word.rx_byte, 8'h00};
                        n_phase     = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_frame_len = len_full;
                        n_elapsed   = 16'd0;
                        if (len_full > 16'(BUF_BYTES)) begin
                            n_phase           = PH_HUNT;
                            n_out             = '0;
                            n_out.reply_valid = 1'b1;
                            n_out.reply_byte  = NACK_CODE;
                            n_out.last        = 1'b1;
                            n_out_valid       = 1'b1;
                        end else if (len_full == 16'd0) begin
                            n_phase           = PH_DONE;
                            n_out             = '0;
                            n_out.reply_valid = 1'b1;
                            n_out.reply_byte  = ACK_CODE;
                            n_out.last        = 1'b1;
                            n_out.finished    = 1'b1;
                            n_out_valid       = 1'b1;
                        end else begin
                            n_phase    = PH_DATA;
                            n_bytes_rx = '0;
                            n_sum      = 16'd0;
                        end
                    end
                    PH_DATA: begin
                        ram_we     = 1'b1;
                        n_sum      = r_sum + {8'h00, i_in_word.rx_byte};
                        n_bytes_rx = bytes_inc;
                        if (bytes_inc >= len_cnt) begin
                            n_phase   = PH_SUM_HI;
                            n_elapsed = 16'd0;
                        end
                    end
                    PH_SUM_HI: begin
                        n_sum_hi = i_in_word.rx_byte;
                        n_phase  = PH_SUM_LO;
                    end
                    PH_SUM_LO: begin
                        n_phase   = PH_HUNT;
                        n_elapsed = 16'd0;
                        if (sum_recv != r_sum) begin
                            n_out             = '0;
                            n_out.reply_valid = 1'b1;
                            n_out.reply_byte  = NACK_CODE;
                            n_out.last        = 1'b1;
                            n_out_valid       = 1'b1;
                        end else begin
                            n_seq  = SEQ_RD;
                            n_idx  = '0;
                            n_word = 32'd0;
                            n_cnt  = 3'd0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        case (r_seq)
            SEQ_RD: begin
                n_seq = SEQ_CAP;
            end
            SEQ_CAP: begin
                n_word[{r_idx[1:0], 3'b000} +: 8] = ram_rdata;
                n_cnt = r_cnt + 3'd1;
                n_idx = idx_inc;
                if (r_idx[1:0] == 2'd3 || idx_inc == len_cnt) begin
                    n_seq = SEQ_OUT;
                end else begin
                    n_seq = SEQ_RD;
                end
            end
            SEQ_OUT: begin
                if (out_free) begin
                    n_out                  = '0;
                    n_out.reply_valid      = word_last;
                    n_out.reply_byte       = word_last ? ACK_CODE : 8'h00;
                    n_out.write_valid      = 1'b1;
                    n_out.write_address    = r_next_addr;
                    n_out.write_word       = r_word;
                    n_out.write_byte_count = r_cnt;
                    n_out.last             = word_last;
                    n_out_valid            = 1'b1;
                    n_next_addr            = r_next_addr + {29'd0, r_cnt};
                    n_word                 = 32'd0;
                    n_cnt                  = 3'd0;
                    n_seq                  = word_last ? SEQ_IDLE : SEQ_RD;
                end
            end
            default: begin
            end
        endcase

        if (cfg_we) begin
            case (paddr[3:2])
                REG_BASE: begin
                    n_base      = pwdata;
                    n_next_addr = pwdata;
                end
                REG_HDR_TO: n_hdr_to = pwdata[15:0];
                REG_DAT_TO: n_dat_to = pwdata[15:0];
                REG_SUM_TO: n_sum_to = pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RESET;
            r_hdr_to    <= HDR_TO_RESET;
            r_dat_to    <= DAT_TO_RESET;
            r_sum_to    <= SUM_TO_RESET;
            r_phase     <= PH_HUNT;
            r_frame_len <= 16'd0;
            r_bytes_rx  <= '0;
            r_sum       <= 16'd0;
            r_sum_hi    <= 8'd0;
            r_elapsed   <= 16'd0;
            r_next_addr <= BASE_RESET;
            r_seq       <= SEQ_IDLE;
            r_idx       <= '0;
            r_cnt       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_base      <= n_base;
            r_hdr_to    <= n_hdr_to;
            r_dat_to    <= n_dat_to;
            r_sum_to    <= n_sum_to;
            r_phase     <= n_phase;
            r_frame_len <= n_frame_len;
            r_bytes_rx  <= n_bytes_rx;
            r_sum       <= n_sum;
            r_sum_hi    <= n_sum_hi;
            r_elapsed   <= n_elapsed;
            r_next_addr <= n_next_addr;
            r_seq       <= n_seq;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_out  <= n_out;
    end

    always_comb begin
        case (paddr[3:2])
            REG_BASE:   prdata = r_base;
            REG_HDR_TO: prdata = {16'd0, r_hdr_to};
            REG_DAT_TO: prdata = {16'd0, r_dat_to};
            REG_SUM_TO: prdata = {16'd0, r_sum_to};
            default:    prdata = 32'd0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

/* hw/rtl/fbr_ram.sv */
// generic simple dual-port ram with registered read
module fbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/fbr_checker.sv */
// port-level checker for the framed block receiver core, with its bind
`include "framed_block_receiver_core_defines.svh"

module fbr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input fbr_pkg::t_out_word o_out_word
);
    import fbr_pkg::*;

    // stalled word holds
    `FBR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word), "output word changed while stalled")

    // reply codes are ack or nack only
    `FBR_ASSERT_IMP(a_reply_code, i_clk, i_rst_n, o_out_valid && o_out_word.reply_valid, o_out_word.reply_byte == ACK_CODE || o_out_word.reply_byte == NACK_CODE, "bad reply code")

    // byte count agrees with write valid
    `FBR_ASSERT_IMP(a_write_count, i_clk, i_rst_n, o_out_valid, o_out_word.write_valid ? (o_out_word.write_byte_count != 3'd0 && o_out_word.write_byte_count <= 3'd4) : (o_out_word.write_byte_count == 3'd0), "write byte count out of range")

    // words before the last of a frame are full writes without reply
    `FBR_ASSERT_IMP(a_mid_word, i_clk, i_rst_n, o_out_valid && !o_out_word.last, o_out_word.write_valid && !o_out_word.reply_valid && o_out_word.write_byte_count == 3'd4, "bad non-last result")

    // finished only on a final ack with no write
    `FBR_ASSERT_IMP(a_finished, i_clk, i_rst_n, o_out_valid && o_out_word.finished, o_out_word.last && o_out_word.reply_byte == ACK_CODE && !o_out_word.write_valid, "bad finished result")

endmodule

bind framed_block_receiver_core fbr_checker u_fbr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_word (o_out_word)
);
